### rtl/core/mkw_pkg.sv
// shared types, register indexes and constants for the mouse-key motion and warp engine
package mkw_pkg;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  // register indexes on the write port
  localparam logic [CFG_INDEX_W-1:0] REG_SPEED_LIMIT = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_DIV    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_LEFT = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_TOP  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_FULL_WIDTH  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_FULL_HEIGHT = 3'd5;

  // register reset values
  localparam logic [6:0]  SPEED_LIMIT_RST = 7'd127;
  localparam logic [1:0]  GRID_DIV_RST    = 2'd2;
  localparam logic [15:0] ORIGIN_RST      = 16'd0;
  localparam logic [15:0] FULL_SIZE_RST   = 16'd32767;

  // item modes
  localparam logic [1:0] MODE_MOVE = 2'd0;
  localparam logic [1:0] MODE_WARP = 2'd1;
  localparam logic [1:0] MODE_END  = 2'd2;

  // warp command bits
  localparam int unsigned CMD_UP    = 0;
  localparam int unsigned CMD_DOWN  = 1;
  localparam int unsigned CMD_LEFT  = 2;
  localparam int unsigned CMD_RIGHT = 3;
  localparam int unsigned CMD_END   = 4;

  // report kinds
  localparam logic KIND_REL = 1'b0;
  localparam logic KIND_ABS = 1'b1;

  // diagonal scale 99/140: floor(m * 99 / 140) == (m * SCALE_MUL) >> SCALE_SHIFT for m <= 128
  localparam int unsigned   SCALE_SHIFT = 20;
  localparam logic [19:0]   SCALE_MUL   = 20'd741510;

  // floor(w / 3) == (w * DIV3_MUL) >> DIV3_SHIFT for any 16-bit w
  localparam int unsigned   DIV3_SHIFT = 17;
  localparam logic [15:0]   DIV3_MUL   = 16'd43691;

  localparam logic [7:0] GAIN_MAX = 8'd255;

  typedef struct packed {
    logic [1:0]        mode;
    logic signed [7:0] move_x;
    logic signed [7:0] move_y;
    logic [7:0]        accel_step;
    logic [4:0]        warp_command;
  } in_item_t;

  typedef struct packed {
    logic              report_kind;
    logic signed [3:0] step_x;
    logic signed [3:0] step_y;
    logic [15:0]       abs_x;
    logic [15:0]       abs_y;
  } out_item_t;

  // shared sequencing and item info handed to both axis lanes
  typedef struct packed {
    logic st_a;
    logic st_b;
    logic commit;
    logic is_move;
    logic is_warp;
    logic diag;
    logic warping;
    logic zoom_center;
  } lane_ctrl_t;

  // per-axis warp direction bits
  typedef struct packed {
    logic near_side;
    logic far_side;
  } lane_dir_t;

endpackage

### rtl/core/mkw_chan_if.sv
// valid/ready channel carrying one payload item
interface mkw_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/mkw_accel.sv
// cubic acceleration curve, two register stages
module mkw_accel (
  input  logic       clk,
  input  logic       st_a,
  input  logic       st_b,
  input  logic [7:0] phase,
  output logic [7:0] gain
);

  logic [15:0] sq_prod;
  logic [7:0]  sq;
  logic [15:0] cu_prod;
  logic [9:0]  curve;

  assign sq_prod = {8'b0, phase} * {8'b0, phase};
  assign cu_prod = {8'b0, sq} * {8'b0, phase};
  // 3*sq - 2*cu + 1, never negative since cu <= sq
  assign curve = ({2'b0, sq} + {1'b0, sq, 1'b0}) - {1'b0, cu_prod[15:8], 1'b0} + 10'd1;

  always_ff @(posedge clk) begin
    if (st_a) begin
      sq <= sq_prod[15:8];
    end
    if (st_b) begin
      gain <= (curve > {2'b0, mkw_pkg::GAIN_MAX}) ? mkw_pkg::GAIN_MAX : curve[7:0];
    end
  end

endmodule

### rtl/core/mkw_axis_lane.sv
// one axis: relative motion with subpixel residue, and warp section narrowing
module mkw_axis_lane (
  input  logic                   clk,
  input  logic                   rst,
  input  mkw_pkg::lane_ctrl_t    ctrl,
  input  mkw_pkg::lane_dir_t     dir,
  input  logic signed [7:0]      move,
  input  logic [7:0]             gain,
  input  logic [6:0]             speed_limit,
  input  logic [1:0]             grid,
  input  logic [15:0]            origin,
  input  logic [15:0]            full_size,
  output logic signed [3:0]      step,
  output logic [15:0]            center
);

  localparam logic [15:0] DIV3_MUL_EXT = mkw_pkg::DIV3_MUL;

  // motion path
  logic [7:0]         mag;
  logic [27:0]        scale_prod;
  logic [6:0]         q_mag;
  logic signed [7:0]  v_q;
  logic signed [7:0]  v_next;
  logic signed [7:0]  q_signed;
  logic signed [17:0] prod_s;
  logic signed [17:0] sum_s;
  logic signed [17:0] lim_s;
  logic signed [17:0] sat_s;
  logic [3:0]         residue;

  // warp path
  logic [15:0] section_pos;
  logic [15:0] section_size;
  logic [15:0] base_pos;
  logic [15:0] base_size;
  logic [31:0] div3_prod;
  logic [15:0] size_div;
  logic [15:0] pos_a;
  logic [15:0] size_a;
  logic [15:0] offset;
  logic [15:0] pos_b;

  assign mag        = move[7] ? 8'(-move) : move;
  assign scale_prod = {20'b0, mag} * {8'b0, mkw_pkg::SCALE_MUL};
  assign q_signed   = move[7] ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
  // scaled axis that rounds to zero keeps its original value
  assign v_next     = (ctrl.diag && q_mag != 7'd0) ? q_signed : move;

  assign prod_s = $signed({{10{v_q[7]}}, v_q}) * $signed({10'b0, gain});
  assign sum_s  = prod_s + $signed({14'b0, residue});
  assign lim_s  = $signed({11'b0, speed_limit});

  always_comb begin
    priority if (sum_s > lim_s) begin
      sat_s = lim_s;
    end else if (sum_s < -lim_s) begin
      sat_s = -lim_s;
    end else begin
      sat_s = sum_s;
    end
  end

  // upper nibble of the saturated sum is the arithmetic shift by 4
  assign step = (v_q == 8'sd0) ? 4'sd0 : $signed(sat_s[7:4]);

  assign base_pos  = ctrl.warping ? section_pos  : origin;
  assign base_size = ctrl.warping ? section_size : full_size;
  assign div3_prod = {16'b0, base_size} * {16'b0, DIV3_MUL_EXT};

  always_comb begin
    unique case (grid)
      2'd3:    size_div = {1'b0, div3_prod[mkw_pkg::DIV3_SHIFT +: 15]};
      2'd2:    size_div = {1'b0, base_size[15:1]};
      default: size_div = base_size;
    endcase
  end

  always_comb begin
    priority if (ctrl.zoom_center) begin
      offset = size_a;
    end else if (dir.far_side) begin
      unique case (grid)
        2'd3:    offset = {size_a[14:0], 1'b0};
        2'd2:    offset = size_a;
        default: offset = 16'd0;
      endcase
    end else if (!dir.near_side) begin
      offset = size_a;
    end else begin
      offset = 16'd0;
    end
  end

  assign center = pos_b + {1'b0, size_a[15:1]};

  always_ff @(posedge clk) begin
    if (ctrl.st_a) begin
      q_mag  <= scale_prod[mkw_pkg::SCALE_SHIFT +: 7];
      pos_a  <= base_pos;
      size_a <= size_div;
    end
    if (ctrl.st_b) begin
      v_q   <= v_next;
      pos_b <= pos_a + offset;
    end
    if (ctrl.commit && ctrl.is_warp) begin
      section_pos  <= pos_b;
      section_size <= size_a;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      residue <= 4'd0;
    end else if (ctrl.commit && ctrl.is_move) begin
      residue <= (v_q == 8'sd0) ? 4'd0 : sat_s[3:0];
    end
  end

endmodule

### rtl/core/mouse_key_motion_and_warp_top.sv
// top level: item sequencing, configuration registers and report merge
//
// Mouse-key engine. Items arrive on the items channel (valid/ready); a
// transfer takes one of: relative move, warp command or end of warping.
// Moves and warp commands give one report on the reports channel; end of
// warping, a warp command with its end bit set, and the unused mode give
// none. Two axis lanes work side by side, each doing the motion or warp math
// for its axis; the output register merges their results into one report.
// Configuration is written through wr_en / wr_index / wr_data; the user must
// write it only while idle, which the block itself does not enforce.
// Sequence: an item is taken in the idle state and passes the work states
// ST_A (scale and divide), ST_B (acceleration curve and section offset) and
// ST_C (gain multiply with saturation and section center), where it commits;
// a new item is taken only after that, once the block is back in idle.
// The output register holds a waiting report, so a new item is taken while
// it waits; if it is still not drained when the next result is due, the
// block holds in its last work cycle until reports.ready.
// Reset (rst, synchronous) clears residues, ends warping, empties the output
// register and loads the configuration reset values.
module mouse_key_motion_and_warp_top (
  input  logic                                clk,
  input  logic                                rst,
  mkw_chan_if.sink                            items,
  mkw_chan_if.source                          reports,
  input  logic                                wr_en,
  input  logic [mkw_pkg::CFG_INDEX_W-1:0]     wr_index,
  input  logic [mkw_pkg::CFG_DATA_W-1:0]      wr_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_A    = 2'd1;
  localparam logic [1:0] ST_B    = 2'd2;
  localparam logic [1:0] ST_C    = 2'd3;

  logic [1:0]  state;
  logic [1:0]  state_next;

  logic [6:0]  speed_limit;
  logic [1:0]  grid_divisions;
  logic [15:0] warp_origin_left;
  logic [15:0] warp_origin_top;
  logic [15:0] warp_full_width;
  logic [15:0] warp_full_height;

  mkw_pkg::in_item_t   item;
  mkw_pkg::out_item_t  report;
  mkw_pkg::out_item_t  report_next;
  logic                report_valid;
  logic                warping_active;

  logic                 accept;
  logic                 is_move;
  logic                 is_warp;
  logic                 produces;
  logic                 out_free;
  logic                 commit;
  logic [1:0]           grid;
  logic [7:0]           gain;
  mkw_pkg::lane_ctrl_t  ctrl;
  mkw_pkg::lane_dir_t   dir_x;
  mkw_pkg::lane_dir_t   dir_y;
  logic signed [3:0]    step_x;
  logic signed [3:0]    step_y;
  logic [15:0]          center_x;
  logic [15:0]          center_y;

  assign items.ready = (state == ST_IDLE);
  assign accept      = items.valid && items.ready;

  assign is_move  = (item.mode == mkw_pkg::MODE_MOVE);
  assign is_warp  = (item.mode == mkw_pkg::MODE_WARP);
  assign produces = is_move || (is_warp && !item.warp_command[mkw_pkg::CMD_END]);
  assign out_free = !report_valid || reports.ready;
  assign commit   = (state == ST_C) && (!produces || out_free);

  // grid of zero behaves as one
  assign grid = (grid_divisions == 2'd0) ? 2'd1 : grid_divisions;

  assign ctrl.st_a        = (state == ST_A);
  assign ctrl.st_b        = (state == ST_B);
  assign ctrl.commit      = commit;
  assign ctrl.is_move     = is_move;
  assign ctrl.is_warp     = is_warp;
  assign ctrl.diag        = (item.move_x != 8'sd0) && (item.move_y != 8'sd0);
  assign ctrl.warping     = warping_active;
  assign ctrl.zoom_center = item.warp_command[mkw_pkg::CMD_UP] &&
                            item.warp_command[mkw_pkg::CMD_DOWN];

  assign dir_x.near_side = item.warp_command[mkw_pkg::CMD_LEFT];
  assign dir_x.far_side  = item.warp_command[mkw_pkg::CMD_RIGHT];
  assign dir_y.near_side = item.warp_command[mkw_pkg::CMD_UP];
  assign dir_y.far_side  = item.warp_command[mkw_pkg::CMD_DOWN];

  mkw_accel u_accel (
    .clk   (clk),
    .st_a  (ctrl.st_a),
    .st_b  (ctrl.st_b),
    .phase (item.accel_step),
    .gain  (gain)
  );

  mkw_axis_lane u_lane_x (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .dir         (dir_x),
    .move        (item.move_x),
    .gain        (gain),
    .speed_limit (speed_limit),
    .grid        (grid),
    .origin      (warp_origin_left),
    .full_size   (warp_full_width),
    .step        (step_x),
    .center      (center_x)
  );

  mkw_axis_lane u_lane_y (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .dir         (dir_y),
    .move        (item.move_y),
    .gain        (gain),
    .speed_limit (speed_limit),
    .grid        (grid),
    .origin      (warp_origin_top),
    .full_size   (warp_full_height),
    .step        (step_y),
    .center      (center_y)
  );

  always_comb begin
    unique case (state)
      ST_IDLE: state_next = accept ? ST_A : ST_IDLE;
      ST_A:    state_next = ST_B;
      ST_B:    state_next = ST_C;
      ST_C:    state_next = commit ? ST_IDLE : ST_C;
      default: state_next = ST_IDLE;
    endcase
  end

  // merge lane results into one report
  always_comb begin
    if (is_move) begin
      report_next.report_kind = mkw_pkg::KIND_REL;
      report_next.step_x      = step_x;
      report_next.step_y      = step_y;
      report_next.abs_x       = 16'd0;
      report_next.abs_y       = 16'd0;
    end else begin
      report_next.report_kind = mkw_pkg::KIND_ABS;
      report_next.step_x      = 4'sd0;
      report_next.step_y      = 4'sd0;
      report_next.abs_x       = center_x;
      report_next.abs_y       = center_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      report_valid   <= 1'b0;
      warping_active <= 1'b0;
    end else begin
      state <= state_next;
      if (commit && produces) begin
        report_valid <= 1'b1;
      end else if (reports.ready) begin
        report_valid <= 1'b0;
      end
      // the unused mode leaves warping as it is
      if (commit) begin
        if (is_warp) begin
          warping_active <= !item.warp_command[mkw_pkg::CMD_END];
        end else if (is_move || item.mode == mkw_pkg::MODE_END) begin
          warping_active <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= items.data;
    end
    if (commit && produces) begin
      report <= report_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_limit      <= mkw_pkg::SPEED_LIMIT_RST;
      grid_divisions   <= mkw_pkg::GRID_DIV_RST;
      warp_origin_left <= mkw_pkg::ORIGIN_RST;
      warp_origin_top  <= mkw_pkg::ORIGIN_RST;
      warp_full_width  <= mkw_pkg::FULL_SIZE_RST;
      warp_full_height <= mkw_pkg::FULL_SIZE_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        mkw_pkg::REG_SPEED_LIMIT: speed_limit      <= wr_data[6:0];
        mkw_pkg::REG_GRID_DIV:    grid_divisions   <= wr_data[1:0];
        mkw_pkg::REG_ORIGIN_LEFT: warp_origin_left <= wr_data;
        mkw_pkg::REG_ORIGIN_TOP:  warp_origin_top  <= wr_data;
        mkw_pkg::REG_FULL_WIDTH:  warp_full_width  <= wr_data;
        mkw_pkg::REG_FULL_HEIGHT: warp_full_height <= wr_data;
        default: ;
      endcase
    end
  end

  assign reports.valid = report_valid;
  assign reports.data  = report;

  // a transfer always starts the work sequence
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_A)
    else $error("accepted item did not enter the first work cycle");

  // a committed move always ends warping
  a_move_ends_warp: assert property (@(posedge clk) disable iff (rst)
    commit && is_move |=> !warping_active)
    else $error("warping still active after a move");

  // relative reports carry no absolute position
  a_rel_no_abs: assert property (@(posedge clk) disable iff (rst)
    reports.valid && reports.data.report_kind == mkw_pkg::KIND_REL |->
      reports.data.abs_x == 16'd0 && reports.data.abs_y == 16'd0)
    else $error("relative report with nonzero absolute fields");

  // a pending report is never overwritten before it is taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    report_valid && !reports.ready |=> $stable(report))
    else $error("waiting report changed before transfer");

endmodule

### test/testbench.sv
// testbench for the mouse-key motion and warp engine: self-checking, random stimulus and idling
`timescale 1ns / 1ps

module testbench;

  localparam logic [1:0] MODE_UNUSED    = 2'd3;
  localparam int         DIAG_NUM       = 99;
  localparam int         DIAG_DEN       = 140;
  localparam int         HOLDOFF_CYCLES = 300;
  localparam int         STALL_LIMIT    = 3000;
  localparam int         DRAIN_CYCLES   = 8;
  localparam int         PHASES         = 12;
  localparam int         PHASE_ITEMS    = 128;

  logic                            clk;
  logic                            rst;
  logic                            wr_en;
  logic [mkw_pkg::CFG_INDEX_W-1:0] wr_index;
  logic [mkw_pkg::CFG_DATA_W-1:0]  wr_data;

  mkw_chan_if #(.T(mkw_pkg::in_item_t))  items_ch ();
  mkw_chan_if #(.T(mkw_pkg::out_item_t)) reports_ch ();

  mouse_key_motion_and_warp_top uut (
    .clk      (clk),
    .rst      (rst),
    .items    (items_ch),
    .reports  (reports_ch),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  // shadow copy of the configuration registers
  logic [6:0]  cfg_speed_limit;
  logic [1:0]  cfg_grid;
  logic [15:0] cfg_left;
  logic [15:0] cfg_top;
  logic [15:0] cfg_width;
  logic [15:0] cfg_height;

  // shadow copy of the engine state
  logic [3:0]  res_x;
  logic [3:0]  res_y;
  logic        warping;
  logic [15:0] sec_left;
  logic [15:0] sec_top;
  logic [15:0] sec_width;
  logic [15:0] sec_height;

  mkw_pkg::in_item_t  key_items[$];
  mkw_pkg::out_item_t predicted_reports[$];
  mkw_pkg::out_item_t predicted;
  mkw_pkg::out_item_t wanted;

  int items_queued;
  int mismatches;
  int sender_idle_pct;
  int receiver_stall_pct;
  int holdoff_requests;
  int holdoffs_served;
  int holdoff_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] curve_gain(logic [7:0] phase);
    int p, sq, cu, r;
    p  = int'(phase);
    sq = (p * p) >> 8;
    cu = (sq * p) >> 8;
    r  = 3 * sq - 2 * cu + 1;
    if (r > int'(mkw_pkg::GAIN_MAX) || r < 0) r = int'(mkw_pkg::GAIN_MAX);
    return r[7:0];
  endfunction

  // one axis: saturated sum of residue and accelerated motion, returns the pixel step
  function automatic logic [3:0] axis_motion(int v, int gain, inout logic [3:0] res);
    int lim, sum, u;
    lim = int'(cfg_speed_limit);
    if (v == 0) begin
      res = 4'd0;
      return 4'd0;
    end
    sum = int'(res) + v * gain;
    if (sum > lim) sum = lim;
    else if (sum < -lim) sum = -lim;
    u   = sum + 128;
    res = u[3:0];
    return 4'((u >> 4) - 8);
  endfunction

  function automatic bit compute_report(mkw_pkg::in_item_t it, output mkw_pkg::out_item_t rep);
    int x, y, sx, sy, gain, g, far;
    rep = '0;
    case (it.mode)
      mkw_pkg::MODE_MOVE: begin
        x    = int'(it.move_x);
        y    = int'(it.move_y);
        gain = int'(curve_gain(it.accel_step));
        if (x != 0 && y != 0) begin
          sx = x * DIAG_NUM / DIAG_DEN;
          sy = y * DIAG_NUM / DIAG_DEN;
          if (sx != 0) x = sx;
          if (sy != 0) y = sy;
        end
        rep.report_kind = mkw_pkg::KIND_REL;
        rep.step_x      = axis_motion(x, gain, res_x);
        rep.step_y      = axis_motion(y, gain, res_y);
        warping         = 1'b0;
        return 1'b1;
      end
      mkw_pkg::MODE_WARP: begin
        g = (cfg_grid == 2'd0) ? 1 : int'(cfg_grid);
        if (!warping) begin
          sec_left   = cfg_left;
          sec_top    = cfg_top;
          sec_width  = cfg_width;
          sec_height = cfg_height;
          warping    = 1'b1;
        end
        if (it.warp_command[mkw_pkg::CMD_END]) begin
          warping = 1'b0;
          return 1'b0;
        end
        sec_width  = 16'(int'(sec_width) / g);
        sec_height = 16'(int'(sec_height) / g);
        if (it.warp_command[mkw_pkg::CMD_UP] && it.warp_command[mkw_pkg::CMD_DOWN]) begin
          // zoom into the middle section
          sec_left = sec_left + sec_width;
          sec_top  = sec_top + sec_height;
        end else begin
          far = g - 1;
          if (it.warp_command[mkw_pkg::CMD_DOWN])
            sec_top = 16'(int'(sec_top) + int'(sec_height) * far);
          else if (!it.warp_command[mkw_pkg::CMD_UP])
            sec_top = sec_top + sec_height;
          if (it.warp_command[mkw_pkg::CMD_RIGHT])
            sec_left = 16'(int'(sec_left) + int'(sec_width) * far);
          else if (!it.warp_command[mkw_pkg::CMD_LEFT])
            sec_left = sec_left + sec_width;
        end
        rep.report_kind = mkw_pkg::KIND_ABS;
        rep.abs_x       = sec_left + (sec_width >> 1);
        rep.abs_y       = sec_top + (sec_height >> 1);
        return 1'b1;
      end
      mkw_pkg::MODE_END: begin
        warping = 1'b0;
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic void check_field(string name, logic signed [17:0] want,
                                      logic signed [17:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // driver: offers queued items, predicts the report of each transfer
  always @(posedge clk) begin
    if (rst) begin
      items_ch.valid <= 1'b0;
    end else begin
      if (items_ch.valid && items_ch.ready) begin
        if (compute_report(items_ch.data, predicted)) predicted_reports.push_back(predicted);
      end
      if (!items_ch.valid || items_ch.ready) begin
        if (key_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          items_ch.data  <= key_items.pop_front();
          items_ch.valid <= 1'b1;
        end else begin
          items_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each report transfer, drives ready with random stalls and hold-offs
  always @(posedge clk) begin
    if (rst) begin
      reports_ch.ready <= 1'b0;
    end else begin
      if (reports_ch.valid && reports_ch.ready) begin
        if (predicted_reports.size() == 0) begin
          $error("report with no pending expectation, kind %0d", reports_ch.data.report_kind);
          mismatches++;
        end else begin
          wanted = predicted_reports.pop_front();
          check_field("report_kind", 18'(wanted.report_kind),
                      18'(reports_ch.data.report_kind));
          check_field("step_x", 18'(wanted.step_x), 18'(reports_ch.data.step_x));
          check_field("step_y", 18'(wanted.step_y), 18'(reports_ch.data.step_y));
          check_field("abs_x", 18'(wanted.abs_x), 18'(reports_ch.data.abs_x));
          check_field("abs_y", 18'(wanted.abs_y), 18'(reports_ch.data.abs_y));
        end
      end
      if (holdoff_left != 0) begin
        holdoff_left--;
        reports_ch.ready <= 1'b0;
      end else if (holdoffs_served != holdoff_requests) begin
        holdoffs_served++;
        holdoff_left = HOLDOFF_CYCLES;
        reports_ch.ready <= 1'b0;
      end else begin
        reports_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((items_ch.valid && items_ch.ready) || (reports_ch.valid && reports_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("mouse_key_motion_and_warp_top test failed");
    $finish;
  end

  task automatic push_item(logic [1:0] mode, logic [7:0] x, logic [7:0] y,
                           logic [7:0] accel, logic [4:0] cmd);
    mkw_pkg::in_item_t it;
    it.mode         = mode;
    it.move_x       = x;
    it.move_y       = y;
    it.accel_step   = accel;
    it.warp_command = cmd;
    key_items.push_back(it);
    if (mode != MODE_UNUSED) items_queued++;
  endtask

  task automatic wait_for_drain();
    do @(negedge clk);
    while (key_items.size() != 0 || items_ch.valid || predicted_reports.size() != 0);
  endtask

  task automatic set_register(logic [mkw_pkg::CFG_INDEX_W-1:0] idx, logic [15:0] val);
    @(posedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    case (idx)
      mkw_pkg::REG_SPEED_LIMIT: cfg_speed_limit = val[6:0];
      mkw_pkg::REG_GRID_DIV:    cfg_grid        = val[1:0];
      mkw_pkg::REG_ORIGIN_LEFT: cfg_left        = val;
      mkw_pkg::REG_ORIGIN_TOP:  cfg_top         = val;
      mkw_pkg::REG_FULL_WIDTH:  cfg_width       = val;
      mkw_pkg::REG_FULL_HEIGHT: cfg_height      = val;
      default: ;
    endcase
  endtask

  task automatic apply_config(logic [6:0] speed, logic [1:0] grid, logic [15:0] left,
                              logic [15:0] top, logic [15:0] w, logic [15:0] h);
    set_register(mkw_pkg::REG_SPEED_LIMIT, 16'(speed));
    set_register(mkw_pkg::REG_GRID_DIV, 16'(grid));
    set_register(mkw_pkg::REG_ORIGIN_LEFT, left);
    set_register(mkw_pkg::REG_ORIGIN_TOP, top);
    set_register(mkw_pkg::REG_FULL_WIDTH, w);
    set_register(mkw_pkg::REG_FULL_HEIGHT, h);
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  function automatic logic [15:0] edge_or_random16();
    case ($urandom_range(3))
      0:       return 16'h0000;
      1:       return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_axis();
    case ($urandom_range(4))
      0:       return 8'd0;
      1:       return $urandom_range(1) ? 8'($urandom_range(1, 8)) : -8'($urandom_range(1, 8));
      2:       return $urandom_range(1) ? 8'd127 : 8'h80;
      default: return 8'($urandom);
    endcase
  endfunction

  // random traffic: held keys with rising acceleration, warp walks, and noise
  task automatic fill_random(int count);
    int goal, len, accel, step, kind;
    logic [7:0] dx, dy;
    goal = items_queued + count;
    while (items_queued < goal) begin
      kind = $urandom_range(99);
      if (kind < 40) begin
        len   = $urandom_range(1, 8);
        dx    = pick_axis();
        dy    = pick_axis();
        accel = $urandom_range(1) ? 0 : $urandom_range(255);
        step  = $urandom_range(1, 64);
        repeat (len) begin
          push_item(mkw_pkg::MODE_MOVE, dx, dy, 8'(accel), 5'($urandom));
          accel = (accel + step > 255) ? 255 : accel + step;
        end
      end else if (kind < 75) begin
        len = $urandom_range(1, 5);
        repeat (len) push_item(mkw_pkg::MODE_WARP, 8'($urandom), 8'($urandom), 8'($urandom),
                               {1'b0, 4'($urandom)});
        case ($urandom_range(3))
          0, 1: push_item(mkw_pkg::MODE_WARP, 8'($urandom), 8'($urandom), 8'($urandom),
                          {1'b1, 4'($urandom)});
          2:    push_item(mkw_pkg::MODE_END, 8'($urandom), 8'($urandom), 8'($urandom),
                          5'($urandom));
          default: ;
        endcase
      end else begin
        push_item(2'($urandom_range(3)), 8'($urandom), 8'($urandom), 8'($urandom),
                  5'($urandom));
      end
    end
  endtask

  initial begin
    rst                = 1'b1;
    wr_en              = 1'b0;
    wr_index           = '0;
    wr_data            = '0;
    items_ch.valid     = 1'b0;
    items_ch.data      = '0;
    reports_ch.ready   = 1'b0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    holdoff_requests   = 0;
    holdoffs_served    = 0;
    holdoff_left       = 0;
    items_queued       = 0;
    mismatches         = 0;
    cfg_speed_limit    = mkw_pkg::SPEED_LIMIT_RST;
    cfg_grid           = mkw_pkg::GRID_DIV_RST;
    cfg_left           = mkw_pkg::ORIGIN_RST;
    cfg_top            = mkw_pkg::ORIGIN_RST;
    cfg_width          = mkw_pkg::FULL_SIZE_RST;
    cfg_height         = mkw_pkg::FULL_SIZE_RST;
    res_x              = '0;
    res_y              = '0;
    warping            = 1'b0;
    sec_left           = '0;
    sec_top            = '0;
    sec_width          = '0;
    sec_height         = '0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed items under the reset configuration
    push_item(mkw_pkg::MODE_MOVE, 8'd127, 8'd0, 8'd255, 5'($urandom));
    push_item(mkw_pkg::MODE_MOVE, 8'h80, 8'd0, 8'd255, 5'($urandom));
    push_item(mkw_pkg::MODE_MOVE, 8'd0, 8'd0, 8'd0, 5'($urandom));
    push_item(mkw_pkg::MODE_MOVE, 8'd1, 8'd1, 8'd0, 5'($urandom));
    push_item(mkw_pkg::MODE_MOVE, 8'h80, 8'd127, 8'd128, 5'($urandom));
    push_item(mkw_pkg::MODE_MOVE, 8'd0, 8'hff, 8'd255, 5'($urandom));
    push_item(mkw_pkg::MODE_MOVE, 8'd5, 8'hfd, 8'd37, 5'($urandom));
    push_item(mkw_pkg::MODE_WARP, 8'($urandom), 8'($urandom), 8'($urandom), 5'b00000);
    push_item(mkw_pkg::MODE_WARP, 8'($urandom), 8'($urandom), 8'($urandom), 5'b00011);
    push_item(mkw_pkg::MODE_WARP, 8'($urandom), 8'($urandom), 8'($urandom), 5'b01010);
    push_item(mkw_pkg::MODE_WARP, 8'($urandom), 8'($urandom), 8'($urandom), 5'b00101);
    push_item(mkw_pkg::MODE_WARP, 8'($urandom), 8'($urandom), 8'($urandom), 5'b10000);
    push_item(mkw_pkg::MODE_WARP, 8'($urandom), 8'($urandom), 8'($urandom), 5'b01100);
    push_item(mkw_pkg::MODE_END, 8'($urandom), 8'($urandom), 8'($urandom), 5'($urandom));
    push_item(mkw_pkg::MODE_WARP, 8'($urandom), 8'($urandom), 8'($urandom), 5'b11111);
    push_item(MODE_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom), 5'($urandom));
    push_item(mkw_pkg::MODE_MOVE, 8'd127, 8'd127, 8'd255, 5'($urandom));
    push_item(mkw_pkg::MODE_MOVE, 8'h80, 8'h80, 8'd200, 5'($urandom));
    push_item(mkw_pkg::MODE_WARP, 8'($urandom), 8'($urandom), 8'($urandom), 5'b01111);
    push_item(mkw_pkg::MODE_END, 8'($urandom), 8'($urandom), 8'($urandom), 5'($urandom));

    for (int p = 0; p < PHASES; p++) begin
      wait_for_drain();
      // items with no report may still be in flight
      repeat (DRAIN_CYCLES) @(negedge clk);
      case (p % 4)
        0:       begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1:       begin sender_idle_pct = 50; receiver_stall_pct = 0;  end
        2:       begin sender_idle_pct = 0;  receiver_stall_pct = 50; end
        default: begin sender_idle_pct = 32; receiver_stall_pct = 32; end
      endcase
      case (p)
        0: apply_config(mkw_pkg::SPEED_LIMIT_RST, mkw_pkg::GRID_DIV_RST,
                        mkw_pkg::ORIGIN_RST, mkw_pkg::ORIGIN_RST,
                        mkw_pkg::FULL_SIZE_RST, mkw_pkg::FULL_SIZE_RST);
        1: apply_config(7'd0, 2'd3, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        2: apply_config(7'd1, 2'd0, 16'($urandom), 16'($urandom), 16'd0, 16'd0);
        3: apply_config(7'($urandom), 2'd1, 16'd0, 16'd0, 16'hffff, 16'($urandom));
        default: apply_config($urandom_range(1) ? 7'($urandom)
                                                : ($urandom_range(1) ? 7'd127 : 7'd0),
                              2'($urandom), edge_or_random16(), edge_or_random16(),
                              edge_or_random16(), edge_or_random16());
      endcase
      @(negedge clk);
      // long receiver hold-off while the sender keeps offering
      if (p == 0 || p == 4) holdoff_requests++;
      fill_random(PHASE_ITEMS / 2);
      // sender pauses until every report is back
      if (p == 5) wait_for_drain();
      fill_random(PHASE_ITEMS / 2);
    end

    wait_for_drain();
    repeat (20) @(negedge clk);
    if (mismatches == 0)
      $display("mouse_key_motion_and_warp_top test passed");
    else
      $display("mouse_key_motion_and_warp_top test failed");
    $finish;
  end

endmodule

### filelist.f
rtl/core/mkw_pkg.sv
rtl/core/mkw_chan_if.sv
rtl/core/mkw_accel.sv
rtl/core/mkw_axis_lane.sv
rtl/core/mouse_key_motion_and_warp_top.sv
test/testbench.sv
